### hdl/oamu_pkg.sv
package oamu_pkg;

	localparam int UPC_W = 5;

	// item kinds
	localparam logic [1:0] FUNC_RESOLVE = 2'd0;
	localparam logic [1:0] FUNC_WMEM    = 2'd1;
	localparam logic [1:0] FUNC_WREG    = 2'd2;

	// addressing modes
	localparam logic [2:0] MODE_REG      = 3'd0;
	localparam logic [2:0] MODE_DEF      = 3'd1;
	localparam logic [2:0] MODE_AINC     = 3'd2;
	localparam logic [2:0] MODE_AINC_DEF = 3'd3;
	localparam logic [2:0] MODE_ADEC     = 3'd4;
	localparam logic [2:0] MODE_ADEC_DEF = 3'd5;
	localparam logic [2:0] MODE_INDEX    = 3'd6;
	localparam logic [2:0] MODE_BAD      = 3'd7;

	localparam logic [2:0] REG_PC = 3'd7;
	localparam logic [2:0] REG_SP = 3'd6;

	// memory request select
	localparam logic [2:0] MEM_NONE = 3'd0;
	localparam logic [2:0] MEM_PTR  = 3'd1;
	localparam logic [2:0] MEM_PTR1 = 3'd2;
	localparam logic [2:0] MEM_ADR  = 3'd3;
	localparam logic [2:0] MEM_ADR1 = 3'd4;
	localparam logic [2:0] MEM_WR   = 3'd5;

	// operand word capture
	localparam logic [1:0] CAP_NONE = 2'd0;
	localparam logic [1:0] CAP_LO   = 2'd1;
	localparam logic [1:0] CAP_HI   = 2'd2;
	localparam logic [1:0] CAP_REG  = 2'd3;

	// register file operation
	localparam logic [1:0] ROP_NONE = 2'd0;
	localparam logic [1:0] ROP_INC  = 2'd1;
	localparam logic [1:0] ROP_DEC  = 2'd2;
	localparam logic [1:0] ROP_LOAD = 2'd3;

	// pointer load
	localparam logic [1:0] POP_NONE = 2'd0;
	localparam logic [1:0] POP_REG  = 2'd1;
	localparam logic [1:0] POP_NEW  = 2'd2;

	// effective address load
	localparam logic [2:0] AOP_NONE = 3'd0;
	localparam logic [2:0] AOP_REG  = 3'd1;
	localparam logic [2:0] AOP_NEW  = 3'd2;
	localparam logic [2:0] AOP_TMP  = 3'd3;
	localparam logic [2:0] AOP_SUM  = 3'd4;
	localparam logic [2:0] AOP_RNUM = 3'd5;

	// sequencing
	localparam logic [1:0] J_NEXT   = 2'd0;
	localparam logic [1:0] J_ALWAYS = 2'd1;
	localparam logic [1:0] J_BYTE   = 2'd2;
	localparam logic [1:0] J_DISP   = 2'd3;

	// program entry points
	localparam logic [UPC_W-1:0] S_DISP = 5'd0;
	localparam logic [UPC_W-1:0] S_M0   = 5'd1;
	localparam logic [UPC_W-1:0] S_M1   = 5'd2;
	localparam logic [UPC_W-1:0] S_M2   = 5'd3;
	localparam logic [UPC_W-1:0] S_M3   = 5'd4;
	localparam logic [UPC_W-1:0] S_M4   = 5'd5;
	localparam logic [UPC_W-1:0] S_M5   = 5'd6;
	localparam logic [UPC_W-1:0] S_M6   = 5'd7;
	localparam logic [UPC_W-1:0] S_IX0  = 5'd8;
	localparam logic [UPC_W-1:0] S_IX1  = 5'd9;
	localparam logic [UPC_W-1:0] S_IX2  = 5'd10;
	localparam logic [UPC_W-1:0] S_IX3  = 5'd11;
	localparam logic [UPC_W-1:0] S_IX4  = 5'd12;
	localparam logic [UPC_W-1:0] S_IX5  = 5'd13;
	localparam logic [UPC_W-1:0] S_WA0  = 5'd14;
	localparam logic [UPC_W-1:0] S_WA1  = 5'd15;
	localparam logic [UPC_W-1:0] S_WA2  = 5'd16;
	localparam logic [UPC_W-1:0] S_WA3  = 5'd17;
	localparam logic [UPC_W-1:0] S_WA4  = 5'd18;
	localparam logic [UPC_W-1:0] S_WA5  = 5'd19;
	localparam logic [UPC_W-1:0] S_OP0  = 5'd20;
	localparam logic [UPC_W-1:0] S_OP1  = 5'd21;
	localparam logic [UPC_W-1:0] S_OP2  = 5'd22;
	localparam logic [UPC_W-1:0] S_OP3  = 5'd23;
	localparam logic [UPC_W-1:0] S_OP4  = 5'd24;
	localparam logic [UPC_W-1:0] S_DONE = 5'd25;
	localparam logic [UPC_W-1:0] S_WMEM = 5'd26;
	localparam logic [UPC_W-1:0] S_WREG = 5'd27;

	typedef struct packed {
		logic [2:0]       mem;
		logic [1:0]       cap;
		logic [1:0]       rop;
		logic             rsel7;
		logic             step2;
		logic [1:0]       pop;
		logic [2:0]       aop;
		logic [1:0]       jmp;
		logic [UPC_W-1:0] target;
		logic             last;
	} ctl_t;

	typedef struct packed {
		logic [1:0] func;
		logic [2:0] mode;
		logic       byte_op;
	} stat_t;

	typedef struct packed {
		logic        we;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} mem_req_t;

	typedef struct packed {
		logic [15:0] operand_address;
		logic [15:0] operand_value;
		logic        is_register;
		logic        mode_error;
	} res_t;

	function automatic ctl_t ucode(input logic [UPC_W-1:0] a);
		ctl_t c;
		c = '0;
		case (a)
			S_DISP: c.jmp = J_DISP;
			S_M0: begin
				c.aop = AOP_RNUM;
				c.cap = CAP_REG;
				c.jmp = J_ALWAYS;
				c.target = S_DONE;
			end
			S_M1: begin
				c.aop = AOP_REG;
				c.jmp = J_ALWAYS;
				c.target = S_OP0;
			end
			S_M2: begin
				c.aop = AOP_REG;
				c.rop = ROP_INC;
				c.jmp = J_ALWAYS;
				c.target = S_OP0;
			end
			S_M3: begin
				c.pop = POP_REG;
				c.rop = ROP_INC;
				c.step2 = 1'b1;
				c.jmp = J_ALWAYS;
				c.target = S_WA0;
			end
			S_M4: begin
				c.rop = ROP_DEC;
				c.aop = AOP_NEW;
				c.jmp = J_ALWAYS;
				c.target = S_OP0;
			end
			S_M5: begin
				c.rop = ROP_DEC;
				c.step2 = 1'b1;
				c.pop = POP_NEW;
				c.jmp = J_ALWAYS;
				c.target = S_WA0;
			end
			S_M6: begin
				c.rsel7 = 1'b1;
				c.pop = POP_REG;
				c.rop = ROP_INC;
				c.step2 = 1'b1;
			end
			S_IX0: c.mem = MEM_PTR;
			S_IX1: c.mem = MEM_PTR1;
			S_IX2: c.mem = MEM_NONE;
			S_IX3: c.cap = CAP_LO;
			S_IX4: c.cap = CAP_HI;
			S_IX5: begin
				c.aop = AOP_SUM;
				c.jmp = J_ALWAYS;
				c.target = S_OP0;
			end
			S_WA0: c.mem = MEM_PTR;
			S_WA1: c.mem = MEM_PTR1;
			S_WA2: c.mem = MEM_NONE;
			S_WA3: c.cap = CAP_LO;
			S_WA4: c.cap = CAP_HI;
			S_WA5: c.aop = AOP_TMP;
			S_OP0: c.mem = MEM_ADR;
			S_OP1: c.mem = MEM_ADR1;
			S_OP2: c.mem = MEM_NONE;
			S_OP3: begin
				c.cap = CAP_LO;
				c.jmp = J_BYTE;
				c.target = S_DONE;
			end
			S_OP4: begin
				c.cap = CAP_HI;
				c.jmp = J_ALWAYS;
				c.target = S_DONE;
			end
			S_DONE: c.last = 1'b1;
			S_WMEM: begin
				c.mem = MEM_WR;
				c.last = 1'b1;
			end
			S_WREG: begin
				c.rop = ROP_LOAD;
				c.last = 1'b1;
			end
			default: begin
				c.jmp = J_ALWAYS;
				c.target = S_DONE;
			end
		endcase
		return c;
	endfunction

	function automatic logic [UPC_W-1:0] dispatch(input stat_t s);
		logic [UPC_W-1:0] t;
		t = S_DONE;
		case (s.func)
			FUNC_WMEM: t = S_WMEM;
			FUNC_WREG: t = S_WREG;
			FUNC_RESOLVE: begin
				case (s.mode)
					MODE_REG:      t = S_M0;
					MODE_DEF:      t = S_M1;
					MODE_AINC:     t = S_M2;
					MODE_AINC_DEF: t = S_M3;
					MODE_ADEC:     t = S_M4;
					MODE_ADEC_DEF: t = S_M5;
					MODE_INDEX:    t = S_M6;
					default:       t = S_DONE;
				endcase
			end
			default: t = S_DONE;
		endcase
		return t;
	endfunction

endpackage

### hdl/oamu_mem.sv
module oamu_mem #(
	parameter int MEM_BYTES = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  oamu_pkg::mem_req_t req,
	output logic [7:0]         rdata
);
	import oamu_pkg::*;

	localparam int IDX_W = $clog2(MEM_BYTES);
	localparam logic [16:0] MEM_M = 17'(MEM_BYTES);
	localparam logic [24:0] RECIP = 25'((64'd1 << 32) / MEM_BYTES);

	logic [7:0] mem [MEM_BYTES];

	logic [40:0]      prod1;
	logic [15:0]      a_s1;
	logic [8:0]       q_s1;
	logic             we_s1;
	logic [7:0]       wdata_s1;
	logic [25:0]      prod2;
	logic [16:0]      rem0;
	logic [16:0]      rem1;
	logic [IDX_W-1:0] idx_s2;
	logic             we_s2;
	logic [7:0]       wdata_s2;
	logic [7:0]       rdata_q;

	assign prod1 = {25'd0, req.addr} * {16'd0, RECIP};

	// quotient estimate is exact or one low, one correction covers it
	assign prod2 = {17'd0, q_s1} * {9'd0, MEM_M};
	assign rem0  = {1'b0, a_s1} - prod2[16:0];
	assign rem1  = (rem0 >= MEM_M) ? rem0 - MEM_M : rem0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1 <= 1'b0;
			we_s2 <= 1'b0;
		end else begin
			we_s1 <= req.we;
			we_s2 <= we_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1     <= req.addr;
		q_s1     <= prod1[40:32];
		wdata_s1 <= req.wdata;
		idx_s2   <= rem1[IDX_W-1:0];
		wdata_s2 <= wdata_s1;
	end

	always_ff @(posedge clk) begin
		if (we_s2) begin
			mem[idx_s2] <= wdata_s2;
		end
		rdata_q <= mem[idx_s2];
	end

	assign rdata = rdata_q;

endmodule

### hdl/oamu_seq.sv
module oamu_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                hold,
	input  oamu_pkg::stat_t     stat,
	output oamu_pkg::ctl_t      ctl,
	output logic                en,
	output logic                busy
);
	import oamu_pkg::*;

	logic             busy_q;
	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_nxt;

	assign ctl  = ucode(upc_q);
	assign en   = busy_q && !(ctl.last && hold);
	assign busy = busy_q;

	always_comb begin
		case (ctl.jmp)
			J_NEXT:   upc_nxt = upc_q + 1'b1;
			J_ALWAYS: upc_nxt = ctl.target;
			J_BYTE:   upc_nxt = stat.byte_op ? ctl.target : upc_q + 1'b1;
			J_DISP:   upc_nxt = dispatch(stat);
			default:  upc_nxt = S_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= S_DISP;
		end else if (accept) begin
			busy_q <= 1'b1;
			upc_q  <= S_DISP;
		end else if (en) begin
			if (ctl.last) begin
				busy_q <= 1'b0;
			end else begin
				upc_q <= upc_nxt;
			end
		end
	end

endmodule

### hdl/oamu_dp.sv
module oamu_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          func,
	input  logic [5:0]          mode_reg,
	input  logic                byte_op,
	input  logic [15:0]         load_address,
	input  logic [15:0]         load_data,
	input  oamu_pkg::ctl_t      ctl,
	input  logic                en,
	input  logic [7:0]          rdata,
	output oamu_pkg::stat_t     stat,
	output oamu_pkg::mem_req_t  req,
	output oamu_pkg::res_t      res
);
	import oamu_pkg::*;

	logic [1:0]  func_q;
	logic [5:0]  mr_q;
	logic        byte_q;
	logic [15:0] la_q;
	logic [15:0] ld_q;
	logic [15:0] rf_q [8];
	logic [15:0] ptr_q;
	logic [15:0] adr_q;
	logic [15:0] tmp_q;

	logic [2:0]  rnum;
	logic [2:0]  mode;
	logic [2:0]  rsel;
	logic [15:0] rf_rd;
	logic [1:0]  stepv;
	logic [15:0] upd;
	logic        ok;

	assign rnum  = mr_q[2:0];
	assign mode  = mr_q[5:3];
	assign rsel  = ctl.rsel7 ? REG_PC : rnum;
	assign rf_rd = rf_q[rsel];
	assign stepv = (ctl.step2 || rnum >= REG_SP || !byte_q) ? 2'd2 : 2'd1;
	assign upd   = (ctl.rop == ROP_DEC) ? rf_rd - {14'd0, stepv} : rf_rd + {14'd0, stepv};

	assign stat.func    = func_q;
	assign stat.mode    = mode;
	assign stat.byte_op = byte_q;

	always_comb begin
		req.we    = en && (ctl.mem == MEM_WR);
		req.wdata = ld_q[7:0];
		case (ctl.mem)
			MEM_PTR:  req.addr = ptr_q;
			MEM_PTR1: req.addr = ptr_q + 16'd1;
			MEM_ADR:  req.addr = adr_q;
			MEM_ADR1: req.addr = adr_q + 16'd1;
			MEM_WR:   req.addr = la_q;
			default:  req.addr = 16'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			mr_q   <= mode_reg;
			byte_q <= byte_op;
			la_q   <= load_address;
			ld_q   <= load_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= 16'd0;
			end
		end else if (en) begin
			case (ctl.rop)
				ROP_INC:  rf_q[rsel] <= upd;
				ROP_DEC:  rf_q[rsel] <= upd;
				ROP_LOAD: rf_q[rnum] <= ld_q;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (ctl.pop)
				POP_REG: ptr_q <= rf_rd;
				POP_NEW: ptr_q <= upd;
				default: ;
			endcase
			case (ctl.aop)
				AOP_REG:  adr_q <= rf_rd;
				AOP_NEW:  adr_q <= upd;
				AOP_TMP:  adr_q <= tmp_q;
				AOP_SUM:  adr_q <= rf_rd + tmp_q;
				AOP_RNUM: adr_q <= {13'd0, rnum};
				default:  ;
			endcase
			case (ctl.cap)
				CAP_LO:  tmp_q <= {8'h00, rdata};
				CAP_HI:  tmp_q[15:8] <= rdata;
				CAP_REG: tmp_q <= byte_q ? {8'h00, rf_rd[7:0]} : rf_rd;
				default: ;
			endcase
		end
	end

	assign ok = (func_q == FUNC_RESOLVE) && (mode != MODE_BAD);

	assign res.operand_address = ok ? adr_q : 16'd0;
	assign res.operand_value   = ok ? tmp_q : 16'd0;
	assign res.is_register     = (func_q == FUNC_RESOLVE) && (mode == MODE_REG);
	assign res.mode_error      = (func_q == FUNC_RESOLVE) && (mode == MODE_BAD);

endmodule

### hdl/operand_address_mode_unit_top.sv
// Operand address unit over eight 16-bit registers and a byte memory of MEM_BYTES
// entries. Each input transfer is one item (tuser selects resolve, memory byte write or
// register write) and gives exactly one result transfer. One item is worked on at a
// time by a microprogram; s_tready is low from acceptance until the result is loaded
// into the output register, which then waits for m_tready while the next item runs.
// Write items, mode 7 and an unused function code take no memory read; register mode
// takes its value from the register file; modes 1, 2 and 4 read the operand word or
// byte from memory, and modes 3, 5 and 6 first read a pointer word. Every access goes
// through the single memory port, which reduces the address modulo MEM_BYTES in the
// registered stages s1 and s2 ahead of the registered read. Memory contents are
// undefined until written.
module operand_address_mode_unit_top #(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // mode_reg[5:0], byte_op[6], load_address[22:7], load_data[38:23]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // operand_address[15:0], operand_value[31:16]
	output logic [1:0]  m_tuser   // is_register[0], mode_error[1]
);
	import oamu_pkg::*;

	ctl_t     ctl;
	stat_t    stat;
	mem_req_t req;
	res_t     res;
	logic     en;
	logic     busy;
	logic     accept;
	logic     hold;
	logic     fin;
	logic [7:0] rdata;

	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic [1:0]  out_user_q;

	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;
	assign hold     = out_valid_q && !m_tready;
	assign fin      = en && ctl.last;

	oamu_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.hold   (hold),
		.stat   (stat),
		.ctl    (ctl),
		.en     (en),
		.busy   (busy)
	);

	oamu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.func         (s_tuser),
		.mode_reg     (s_tdata[5:0]),
		.byte_op      (s_tdata[6]),
		.load_address (s_tdata[22:7]),
		.load_data    (s_tdata[38:23]),
		.ctl          (ctl),
		.en           (en),
		.rdata        (rdata),
		.stat         (stat),
		.req          (req),
		.res          (res)
	);

	oamu_mem #(
		.MEM_BYTES (MEM_BYTES)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_data_q <= {res.operand_value, res.operand_address};
			out_user_q <= {res.mode_error, res.is_register};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

`ifndef SYNTHESIS
	a_fin_room: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (!out_valid_q || m_tready))
		else $error("result finished while output register still full");
	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> m_tvalid)
		else $error("finished result not presented");
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input ready right after a transfer");
	a_wr_kind: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |-> (stat.func == FUNC_WMEM))
		else $error("memory write outside a memory write item");
`endif

endmodule

### verif/oamu_checker.sv
module oamu_checker #(
	parameter int MEM_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import oamu_pkg::*;

	logic [15:0] reg_image [8];
	logic [7:0]  mem_image [MEM_BYTES];
	res_t        awaited_operands [$];
	int          mismatches = 0;

	assign errors = mismatches;

	function automatic logic [7:0] fetch_byte(input logic [15:0] a);
		return mem_image[a % MEM_BYTES];
	endfunction

	// little-endian, second byte wraps at 16 bits
	function automatic logic [15:0] fetch_word(input logic [15:0] a);
		logic [15:0] a1;
		a1 = a + 16'd1;
		return {fetch_byte(a1), fetch_byte(a)};
	endfunction

	function automatic res_t resolve_operand(input logic [1:0] func, input logic [5:0] mr,
			input logic b, input logic [15:0] la, input logic [15:0] ld);
		res_t        r;
		logic [2:0]  rn;
		logic [2:0]  mode;
		logic [15:0] step;
		logic [15:0] ofs;
		r = '0;
		rn = mr[2:0];
		mode = mr[5:3];
		step = (rn >= REG_SP || !b) ? 16'd2 : 16'd1;
		case (func)
			FUNC_WMEM: mem_image[la % MEM_BYTES] = ld[7:0];
			FUNC_WREG: reg_image[rn] = ld;
			FUNC_RESOLVE: begin
				case (mode)
					MODE_REG: begin
						r.operand_address = {13'd0, rn};
						r.operand_value = b ? {8'h00, reg_image[rn][7:0]} : reg_image[rn];
						r.is_register = 1'b1;
					end
					MODE_DEF: r.operand_address = reg_image[rn];
					MODE_AINC: begin
						r.operand_address = reg_image[rn];
						reg_image[rn] = reg_image[rn] + step;
					end
					MODE_AINC_DEF: begin
						r.operand_address = fetch_word(reg_image[rn]);
						reg_image[rn] = reg_image[rn] + 16'd2;
					end
					MODE_ADEC: begin
						reg_image[rn] = reg_image[rn] - step;
						r.operand_address = reg_image[rn];
					end
					MODE_ADEC_DEF: begin
						reg_image[rn] = reg_image[rn] - 16'd2;
						r.operand_address = fetch_word(reg_image[rn]);
					end
					MODE_INDEX: begin
						ofs = fetch_word(reg_image[REG_PC]);
						reg_image[REG_PC] = reg_image[REG_PC] + 16'd2;
						r.operand_address = reg_image[rn] + ofs;
					end
					default: r.mode_error = 1'b1;
				endcase
				if (mode != MODE_REG && mode != MODE_BAD) begin
					r.operand_value = b ? {8'h00, fetch_byte(r.operand_address)}
						: fetch_word(r.operand_address);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				reg_image[i] = '0;
			awaited_operands.delete();
			pending <= 0;
		end else begin
			// result transfer first: it can only belong to an earlier item
			if (m_tvalid && m_tready) begin
				got = {m_tdata[15:0], m_tdata[31:16], m_tuser[0], m_tuser[1]};
				if (awaited_operands.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none actual %h", $time, got);
				end else begin
					want = awaited_operands.pop_front();
					compare_field("operand_address", want.operand_address,
						got.operand_address);
					compare_field("operand_value", want.operand_value, got.operand_value);
					compare_field("is_register", {15'd0, want.is_register},
						{15'd0, got.is_register});
					compare_field("mode_error", {15'd0, want.mode_error},
						{15'd0, got.mode_error});
				end
			end
			if (s_tvalid && s_tready) begin
				awaited_operands.push_back(resolve_operand(s_tuser, s_tdata[5:0], s_tdata[6],
					s_tdata[22:7], s_tdata[38:23]));
			end
			pending <= awaited_operands.size();
		end
	end

endmodule

### verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import oamu_pkg::*;

	localparam int MEM_BYTES = 65536;
	localparam int RANDOM_ITEMS = 750;
	localparam int LONG_HOLD = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	int          errors;
	int          pending;

	// stimulus-side view, used only to keep reads on written bytes
	logic [15:0] plan_regs [8];
	logic [7:0]  plan_mem [MEM_BYTES];
	bit          plan_written [MEM_BYTES];

	int burst_left = 0;
	int items_sent = 0;
	int ignored_sent = 0;
	int fills = 0;
	int reg_loads = 0;
	int mode_hits [8];
	int hold_requests = 0;
	int hold_served = 0;
	int cycle_count = 0;

	operand_address_mode_unit_top #(.MEM_BYTES(MEM_BYTES)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	oamu_checker #(.MEM_BYTES(MEM_BYTES)) i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.pending  (pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: stretches of always ready, coin flips or mostly stalled
	initial begin : rx_stall
		int span;
		int kind;
		int hold_left;
		span = 0;
		kind = 0;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = LONG_HOLD;
			end
			if (span == 0) begin
				kind = $urandom_range(0, 2);
				span = $urandom_range(20, 150);
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (kind)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_item(input logic [1:0] func, input logic [5:0] mr, input logic b,
			input logic [15:0] la, input logic [15:0] ld);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {1'b0, ld, la, b, mr};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (func == FUNC_UNUSED)
			ignored_sent++;
		else
			items_sent++;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_byte(input logic [15:0] a, input logic [15:0] d);
		plan_mem[a] = d[7:0];
		plan_written[a] = 1'b1;
		send_item(FUNC_WMEM, 6'($urandom), 1'($urandom), a, d);
	endtask

	task automatic write_reg(input logic [2:0] rn, input logic [15:0] v);
		plan_regs[rn] = v;
		reg_loads++;
		send_item(FUNC_WREG, {3'($urandom), rn}, 1'($urandom), 16'($urandom), v);
	endtask

	function automatic logic [15:0] plan_word(input logic [15:0] a);
		logic [15:0] a1;
		a1 = a + 16'd1;
		return {plan_mem[a1], plan_mem[a]};
	endfunction

	// load any byte the operand will touch that was never written
	task automatic fill_operand(input logic [15:0] a, input logic b);
		logic [15:0] a1;
		a1 = a + 16'd1;
		if (!plan_written[a]) begin
			fills++;
			write_byte(a, 16'($urandom));
		end
		if (!b && !plan_written[a1]) begin
			fills++;
			write_byte(a1, 16'($urandom));
		end
	endtask

	task automatic resolve(input logic [2:0] mode, input logic [2:0] rn, input logic b);
		logic [15:0] step;
		logic [15:0] ofs;
		step = (rn >= REG_SP || !b) ? 16'd2 : 16'd1;
		case (mode)
			MODE_DEF: fill_operand(plan_regs[rn], b);
			MODE_AINC: begin
				fill_operand(plan_regs[rn], b);
				plan_regs[rn] = plan_regs[rn] + step;
			end
			MODE_AINC_DEF: begin
				fill_operand(plan_regs[rn], 1'b0);
				fill_operand(plan_word(plan_regs[rn]), b);
				plan_regs[rn] = plan_regs[rn] + 16'd2;
			end
			MODE_ADEC: begin
				plan_regs[rn] = plan_regs[rn] - step;
				fill_operand(plan_regs[rn], b);
			end
			MODE_ADEC_DEF: begin
				plan_regs[rn] = plan_regs[rn] - 16'd2;
				fill_operand(plan_regs[rn], 1'b0);
				fill_operand(plan_word(plan_regs[rn]), b);
			end
			MODE_INDEX: begin
				fill_operand(plan_regs[REG_PC], 1'b0);
				ofs = plan_word(plan_regs[REG_PC]);
				plan_regs[REG_PC] = plan_regs[REG_PC] + 16'd2;
				fill_operand(plan_regs[rn] + ofs, b);
			end
			default: ;
		endcase
		mode_hits[mode]++;
		send_item(FUNC_RESOLVE, {mode, rn}, b, 16'($urandom), 16'($urandom));
	endtask

	function automatic logic [15:0] pick_reg_value;
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 7));
			1: return 16'hFFFF - 16'($urandom_range(0, 7));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int          start;
		bit          held;
		bit          paused;
		logic [2:0]  rn;
		int          pick;
		for (int i = 0; i < 8; i++) begin
			plan_regs[i] = '0;
			mode_hits[i] = 0;
		end
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= FUNC_RESOLVE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		resolve(MODE_REG, 3'd0, 1'b0);
		write_byte(16'hFFFF, 16'hFF5A);
		write_byte(16'h0000, 16'h00C3);
		write_reg(3'd0, 16'hFFFF);
		resolve(MODE_REG, 3'd0, 1'b1);
		resolve(MODE_AINC, 3'd0, 1'b0);
		resolve(MODE_ADEC, 3'd0, 1'b0);
		write_reg(3'd1, 16'h0000);
		resolve(MODE_ADEC, 3'd1, 1'b1);
		resolve(MODE_AINC, 3'd1, 1'b1);
		write_reg(REG_SP, 16'h1001);
		resolve(MODE_AINC, REG_SP, 1'b1);
		resolve(MODE_DEF, REG_SP, 1'b0);
		resolve(MODE_ADEC_DEF, REG_SP, 1'b1);
		write_reg(REG_PC, 16'h0100);
		resolve(MODE_INDEX, REG_PC, 1'b0);
		resolve(MODE_INDEX, 3'd3, 1'b1);
		resolve(MODE_AINC_DEF, REG_PC, 1'b0);
		resolve(MODE_AINC_DEF, 3'd2, 1'b1);
		resolve(MODE_BAD, 3'd5, 1'b0);
		send_item(FUNC_UNUSED, 6'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
		drain();

		// random
		start = items_sent;
		held = 1'b0;
		paused = 1'b0;
		rn = 3'd0;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (!held && items_sent - start > 250) begin
				held = 1'b1;
				hold_requests++;
			end
			if (!paused && items_sent - start > 500) begin
				paused = 1'b1;
				drain();
			end
			if ($urandom_range(0, 1) == 0)
				rn = 3'($urandom_range(0, 7));
			pick = $urandom_range(0, 99);
			if (pick < 10)
				write_reg(rn, pick_reg_value());
			else if (pick < 13)
				resolve(MODE_BAD, rn, 1'($urandom));
			else if (pick < 15)
				send_item(FUNC_UNUSED, 6'($urandom), 1'($urandom), 16'($urandom),
					16'($urandom));
			else
				resolve(3'($urandom_range(0, 6)), rn, 1'($urandom));
		end
		drain();
		repeat (20) @(posedge clk);

		$display("covered %0d transfers in (%0d memory fills, %0d register loads), %0d ignored",
			items_sent, fills, reg_loads, ignored_sent);
		$display("resolves by mode 0-7: %0d %0d %0d %0d %0d %0d %0d %0d", mode_hits[0],
			mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4], mode_hits[5],
			mode_hits[6], mode_hits[7]);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
